@@ src/efbq_pkg.sv @@
package efbq_pkg;

  localparam int QUEUE_DEPTH_DEF = 16;

  localparam int CMD_W      = 2;
  localparam int EPOCH_W    = 32;
  localparam int USER_W     = 32;
  localparam int TAG_W      = 32;
  localparam int SIZE_W     = 20;
  localparam int STATUS_W   = 3;
  localparam int MAXEV_W    = 5;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 20;

  localparam logic [MAXEV_W-1:0] MAX_EVENTS_RST = 5'd16;
  localparam logic [SIZE_W-1:0]  MAX_BYTES_RST  = 20'd65536;

  localparam logic [CFG_IDX_W-1:0] REG_MAX_EVENTS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_BYTES  = 2'd1;

  typedef enum logic [CMD_W-1:0] {
    CMD_ADMIT    = 2'd0,
    CMD_ACTIVATE = 2'd1,
    CMD_RESET    = 2'd2,
    CMD_IGNORED  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    OP_ADMIT,
    OP_ACTIVATE,
    OP_RESET
  } op_kind_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OVERSIZED   = 3'd0,
    ST_QUEUED      = 3'd1,
    ST_STALE       = 3'd2,
    ST_CURRENT     = 3'd3,
    ST_ACT_REJECT  = 3'd4,
    ST_ACT_ACCEPT  = 3'd5,
    ST_RELEASED    = 3'd6,
    ST_RESET_DONE  = 3'd7
  } status_t;

  typedef struct packed {
    op_kind_t             kind;
    logic [EPOCH_W-1:0]   epoch;
    logic [USER_W-1:0]    user;
    logic [TAG_W-1:0]     tag;
    logic [SIZE_W-1:0]    size;
  } op_t;

endpackage

@@ src/efbq_ram.sv @@
module efbq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic                                    re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ src/efbq_front.sv @@
module efbq_front
  import efbq_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [CMD_W-1:0]  in_cmd,
  input  logic [EPOCH_W-1:0] in_epoch,
  input  logic [USER_W-1:0] in_user_id,
  input  logic [TAG_W-1:0]  in_event_tag,
  input  logic [SIZE_W-1:0] in_event_size,
  output logic              op_valid,
  input  logic              op_ready,
  output op_t               op
);

  op_t        fifo_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] cnt_r;

  op_t  op_in;
  logic push;
  logic pop;
  logic keep;

  always_comb begin
    op_in.epoch = in_epoch;
    op_in.user  = in_user_id;
    op_in.tag   = in_event_tag;
    op_in.size  = in_event_size;
    op_in.kind  = OP_ADMIT;
    keep        = 1'b0;
    unique case (cmd_t'(in_cmd))
      CMD_ADMIT: begin
        op_in.kind = OP_ADMIT;
        keep       = 1'b1;
      end
      CMD_ACTIVATE: begin
        op_in.kind = OP_ACTIVATE;
        keep       = 1'b1;
      end
      CMD_RESET: begin
        op_in.kind = OP_RESET;
        keep       = 1'b1;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign in_ready = (cnt_r != 2'd2);
  assign push     = in_valid && in_ready && keep;
  assign op_valid = (cnt_r != 2'd0);
  assign pop      = op_valid && op_ready;
  assign op       = fifo_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_r[wr_ptr_r] <= op_in;
    end
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 2'd1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 2'd1;
      end
    end
  end

endmodule

@@ src/efbq_back.sv @@
module efbq_back
  import efbq_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  op_valid,
  output logic                  op_ready,
  input  op_t                   op,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [STATUS_W-1:0]   out_status,
  output logic                  out_changed,
  output logic [TAG_W-1:0]      out_tag,
  output logic [SIZE_W-1:0]     out_size,
  output logic                  out_last
);

  localparam int HW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW    = $clog2(QUEUE_DEPTH + 1);
  localparam int ENT_W = TAG_W + SIZE_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_EV_CHK,
    S_EV_UPD,
    S_REL_RD,
    S_REL_OUT
  } state_t;

  state_t               state_r, state_nxt;
  op_t                  op_r, op_nxt;
  logic                 has_ctx_r, has_ctx_nxt;
  logic [EPOCH_W-1:0]   act_epoch_r, act_epoch_nxt;
  logic [USER_W-1:0]    act_user_r, act_user_nxt;
  logic [HW-1:0]        head_r, head_nxt;
  logic [CW-1:0]        count_r, count_nxt;
  logic [SIZE_W-1:0]    wb_r, wb_nxt;
  logic [HW-1:0]        rel_ptr_r, rel_ptr_nxt;
  logic [CW-1:0]        rel_left_r, rel_left_nxt;
  logic [MAXEV_W-1:0]   max_events_r, max_events_nxt;
  logic [SIZE_W-1:0]    max_bytes_r, max_bytes_nxt;
  logic                 out_valid_r, out_valid_nxt;
  status_t              out_status_r, out_status_nxt;
  logic                 out_changed_r, out_changed_nxt;
  logic [TAG_W-1:0]     out_tag_r, out_tag_nxt;
  logic [SIZE_W-1:0]    out_size_r, out_size_nxt;
  logic                 out_last_r, out_last_nxt;

  logic [CW-1:0]        lim;
  logic                 out_free;
  logic                 newer;
  logic                 over_budget;
  logic                 must_drop;
  logic [CW:0]          slot_sum;
  logic [HW-1:0]        slot;
  logic                 ram_we;
  logic                 ram_re;
  logic [HW-1:0]        ram_raddr;
  logic [ENT_W-1:0]     ram_rdata;
  logic [TAG_W-1:0]     rd_tag;
  logic [SIZE_W-1:0]    rd_size;

  function automatic logic [HW-1:0] ptr_inc(input logic [HW-1:0] p);
    ptr_inc = (32'(p) == QUEUE_DEPTH - 1) ? '0 : p + 1'b1;
  endfunction

  efbq_ram #(
    .WIDTH (ENT_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_qram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (slot),
    .wdata ({op_r.tag, op_r.size}),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rd_tag  = ram_rdata[ENT_W-1:SIZE_W];
  assign rd_size = ram_rdata[SIZE_W-1:0];

  always_comb begin
    if (max_events_r == '0) begin
      lim = CW'(1);
    end else if (32'(max_events_r) > QUEUE_DEPTH) begin
      lim = CW'(QUEUE_DEPTH);
    end else begin
      lim = CW'(max_events_r);
    end
  end

  assign out_free    = !out_valid_r || out_ready;
  assign newer       = !has_ctx_r || (op_r.epoch > act_epoch_r);
  assign over_budget = ({1'b0, op_r.size} + {1'b0, wb_r}) > {1'b0, max_bytes_r};
  assign must_drop   = (count_r != '0) && ((count_r >= lim) || over_budget);
  assign slot_sum    = (CW + 1)'(head_r) + (CW + 1)'(count_r);
  assign slot        = (slot_sum >= (CW + 1)'(QUEUE_DEPTH)) ?
                       HW'(slot_sum - (CW + 1)'(QUEUE_DEPTH)) : HW'(slot_sum);

  assign op_ready  = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign ram_re    = ((state_r == S_EV_CHK) && must_drop) || (state_r == S_REL_RD);
  assign ram_raddr = (state_r == S_REL_RD) ? rel_ptr_r : head_r;
  assign ram_we    = (state_r == S_EV_CHK) && !must_drop && out_free;

  always_comb begin
    state_nxt       = state_r;
    op_nxt          = op_r;
    has_ctx_nxt     = has_ctx_r;
    act_epoch_nxt   = act_epoch_r;
    act_user_nxt    = act_user_r;
    head_nxt        = head_r;
    count_nxt       = count_r;
    wb_nxt          = wb_r;
    rel_ptr_nxt     = rel_ptr_r;
    rel_left_nxt    = rel_left_r;
    max_events_nxt  = max_events_r;
    max_bytes_nxt   = max_bytes_r;
    out_valid_nxt   = out_valid_r && !out_ready;
    out_status_nxt  = out_status_r;
    out_changed_nxt = out_changed_r;
    out_tag_nxt     = out_tag_r;
    out_size_nxt    = out_size_r;
    out_last_nxt    = out_last_r;

    if (cfg_valid) begin
      if (cfg_index == REG_MAX_EVENTS) begin
        max_events_nxt = cfg_data[MAXEV_W-1:0];
      end else if (cfg_index == REG_MAX_BYTES) begin
        max_bytes_nxt = cfg_data[SIZE_W-1:0];
      end
    end

    unique case (state_r)
      S_IDLE: begin
        if (op_valid) begin
          op_nxt    = op;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (out_free) begin
          out_changed_nxt = 1'b0;
          out_tag_nxt     = '0;
          out_size_nxt    = '0;
          out_last_nxt    = 1'b1;
          state_nxt       = S_IDLE;
          unique case (op_r.kind)
            OP_ADMIT: begin
              priority if (newer && (op_r.size > max_bytes_r)) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = ST_OVERSIZED;
              end else if (newer) begin
                state_nxt = S_EV_CHK;
              end else if ((op_r.epoch != act_epoch_r) || (op_r.user != act_user_r)) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = ST_STALE;
              end else begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = ST_CURRENT;
              end
            end
            OP_ACTIVATE: begin
              out_valid_nxt = 1'b1;
              if (has_ctx_r && (op_r.epoch < act_epoch_r)) begin
                out_status_nxt = ST_ACT_REJECT;
              end else begin
                out_status_nxt  = ST_ACT_ACCEPT;
                out_changed_nxt = !has_ctx_r || (op_r.epoch != act_epoch_r) ||
                                  (op_r.user != act_user_r);
                out_last_nxt    = (count_r == '0);
                has_ctx_nxt     = 1'b1;
                act_epoch_nxt   = op_r.epoch;
                act_user_nxt    = op_r.user;
                wb_nxt          = '0;
                rel_ptr_nxt     = head_r;
                rel_left_nxt    = count_r;
                count_nxt       = '0;
                head_nxt        = '0;
                if (count_r != '0) begin
                  state_nxt = S_REL_RD;
                end
              end
            end
            OP_RESET: begin
              out_valid_nxt  = 1'b1;
              out_status_nxt = ST_RESET_DONE;
              has_ctx_nxt    = 1'b0;
              act_epoch_nxt  = '0;
              act_user_nxt   = '0;
              head_nxt       = '0;
              count_nxt      = '0;
              wb_nxt         = '0;
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end
      S_EV_CHK: begin
        if (must_drop) begin
          state_nxt = S_EV_UPD;
        end else if (out_free) begin
          count_nxt       = count_r + 1'b1;
          wb_nxt          = wb_r + op_r.size;
          out_valid_nxt   = 1'b1;
          out_status_nxt  = ST_QUEUED;
          out_changed_nxt = 1'b0;
          out_tag_nxt     = '0;
          out_size_nxt    = '0;
          out_last_nxt    = 1'b1;
          state_nxt       = S_IDLE;
        end
      end
      S_EV_UPD: begin
        wb_nxt    = (rd_size > wb_r) ? '0 : wb_r - rd_size;
        head_nxt  = ptr_inc(head_r);
        count_nxt = count_r - 1'b1;
        state_nxt = S_EV_CHK;
      end
      S_REL_RD: begin
        state_nxt = S_REL_OUT;
      end
      S_REL_OUT: begin
        if (out_free) begin
          out_valid_nxt   = 1'b1;
          out_status_nxt  = ST_RELEASED;
          out_changed_nxt = 1'b0;
          out_tag_nxt     = rd_tag;
          out_size_nxt    = rd_size;
          out_last_nxt    = (rel_left_r == CW'(1));
          rel_ptr_nxt     = ptr_inc(rel_ptr_r);
          rel_left_nxt    = rel_left_r - 1'b1;
          state_nxt       = (rel_left_r == CW'(1)) ? S_IDLE : S_REL_RD;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    op_r          <= op_nxt;
    out_status_r  <= out_status_nxt;
    out_changed_r <= out_changed_nxt;
    out_tag_r     <= out_tag_nxt;
    out_size_r    <= out_size_nxt;
    out_last_r    <= out_last_nxt;
    rel_ptr_r     <= rel_ptr_nxt;
    if (!rst_n) begin
      state_r      <= S_IDLE;
      has_ctx_r    <= 1'b0;
      act_epoch_r  <= '0;
      act_user_r   <= '0;
      head_r       <= '0;
      count_r      <= '0;
      wb_r         <= '0;
      rel_left_r   <= '0;
      max_events_r <= MAX_EVENTS_RST;
      max_bytes_r  <= MAX_BYTES_RST;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      has_ctx_r    <= has_ctx_nxt;
      act_epoch_r  <= act_epoch_nxt;
      act_user_r   <= act_user_nxt;
      head_r       <= head_nxt;
      count_r      <= count_nxt;
      wb_r         <= wb_nxt;
      rel_left_r   <= rel_left_nxt;
      max_events_r <= max_events_nxt;
      max_bytes_r  <= max_bytes_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_status  = out_status_r;
  assign out_changed = out_changed_r;
  assign out_tag     = out_tag_r;
  assign out_size    = out_size_r;
  assign out_last    = out_last_r;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(QUEUE_DEPTH))
    else $error("held count above queue depth");

  a_drop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EV_UPD) |-> (count_r != '0))
    else $error("drop from empty queue");

  a_reset_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EXEC && op_r.kind == OP_RESET && out_free)
      |=> (count_r == '0 && wb_r == '0 && !has_ctx_r))
    else $error("reset op left state behind");

  a_release_beat: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_REL_OUT && out_free)
      |=> (out_valid_r && out_status_r == ST_RELEASED))
    else $error("release beat missing");
`endif

endmodule

@@ src/epoch_fence_bounded_queue_top.sv @@
// Epoch fence with a bounded event queue. Commands enter a two-entry queue in
// the front end, and a back-end sequencer runs them one at a time against the
// fence state and a single-port-read event RAM with registered read. A stale,
// current, oversized, rejected or reset command passes through the idle and
// execute states only; an admit that queues also visits the check state, plus
// one check and update pass per dropped event, and an activation adds one RAM
// read and one output state per released event. Results leave through an
// output register, so one beat may wait while the next command is taken in.
module epoch_fence_bounded_queue_top
  import efbq_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [CMD_W-1:0]      in_cmd,
  input  logic [EPOCH_W-1:0]    in_epoch,
  input  logic [USER_W-1:0]     in_user_id,
  input  logic [TAG_W-1:0]      in_event_tag,
  input  logic [SIZE_W-1:0]     in_event_size,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [STATUS_W-1:0]   out_status,
  output logic                  out_changed,
  output logic [TAG_W-1:0]      out_tag,
  output logic [SIZE_W-1:0]     out_size,
  output logic                  out_last
);

  logic op_valid;
  logic op_ready;
  op_t  op;

  efbq_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_cmd        (in_cmd),
    .in_epoch      (in_epoch),
    .in_user_id    (in_user_id),
    .in_event_tag  (in_event_tag),
    .in_event_size (in_event_size),
    .op_valid      (op_valid),
    .op_ready      (op_ready),
    .op            (op)
  );

  efbq_back #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .op_valid    (op_valid),
    .op_ready    (op_ready),
    .op          (op),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_status  (out_status),
    .out_changed (out_changed),
    .out_tag     (out_tag),
    .out_size    (out_size),
    .out_last    (out_last)
  );

endmodule

@@ tb/efbq_fence_checker.sv @@
`timescale 1ns / 100ps

module efbq_fence_checker
  import efbq_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  logic [CMD_W-1:0]      in_cmd,
  input  logic [EPOCH_W-1:0]    in_epoch,
  input  logic [USER_W-1:0]     in_user_id,
  input  logic [TAG_W-1:0]      in_event_tag,
  input  logic [SIZE_W-1:0]     in_event_size,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  logic [STATUS_W-1:0]   out_status,
  input  logic                  out_changed,
  input  logic [TAG_W-1:0]      out_tag,
  input  logic [SIZE_W-1:0]     out_size,
  input  logic                  out_last,
  output int                    fail_count,
  output int                    pending
);

  typedef struct packed {
    status_t           status;
    logic              changed;
    logic [TAG_W-1:0]  tag;
    logic [SIZE_W-1:0] size;
    logic              last;
  } beat_t;

  typedef struct packed {
    logic [TAG_W-1:0]  tag;
    logic [SIZE_W-1:0] size;
  } held_t;

  beat_t              due_beats[$];
  held_t              held_events[$];
  logic               has_ctx;
  logic [EPOCH_W-1:0] act_epoch;
  logic [USER_W-1:0]  act_user;
  logic [SIZE_W-1:0]  held_bytes;
  logic [MAXEV_W-1:0] lim_events;
  logic [SIZE_W-1:0]  lim_bytes;
  int                 errors = 0;

  assign fail_count = errors;

  task automatic report_mismatch(input string msg);
    $display("%0t mismatch: %s", $time, msg);
    errors++;
  endtask

  task automatic expect_beat(input status_t st, input logic chg, input logic [TAG_W-1:0] t,
                             input logic [SIZE_W-1:0] s, input logic lst);
    beat_t b;
    b.status  = st;
    b.changed = chg;
    b.tag     = t;
    b.size    = s;
    b.last    = lst;
    due_beats.insert(due_beats.size(), b);
  endtask

  task automatic clear_fence();
    has_ctx    = 1'b0;
    act_epoch  = '0;
    act_user   = '0;
    held_bytes = '0;
    held_events.delete();
  endtask

  task automatic admit_event(input logic [EPOCH_W-1:0] ep, input logic [USER_W-1:0] usr,
                             input logic [TAG_W-1:0] t, input logic [SIZE_W-1:0] s);
    int              cap;
    logic [SIZE_W:0] need;
    held_t           h;
    status_t         st;
    if (!has_ctx || ep > act_epoch) begin
      cap = (lim_events == 0) ? 1 : ((lim_events > QUEUE_DEPTH) ? QUEUE_DEPTH : lim_events);
      if (s > lim_bytes) begin
        st = ST_OVERSIZED;
      end else begin
        need = {1'b0, s} + {1'b0, held_bytes};
        while (held_events.size() > 0 &&
               (held_events.size() >= cap || need > {1'b0, lim_bytes})) begin
          h = held_events.pop_front();
          held_bytes = (h.size > held_bytes) ? '0 : held_bytes - h.size;
          need = {1'b0, s} + {1'b0, held_bytes};
        end
        h.tag  = t;
        h.size = s;
        held_events.insert(held_events.size(), h);
        held_bytes = held_bytes + s;
        st = ST_QUEUED;
      end
    end else if (ep != act_epoch || usr != act_user) begin
      st = ST_STALE;
    end else begin
      st = ST_CURRENT;
    end
    expect_beat(st, 1'b0, '0, '0, 1'b1);
  endtask

  task automatic activate_ctx(input logic [EPOCH_W-1:0] ep, input logic [USER_W-1:0] usr);
    logic  chg;
    held_t h;
    if (has_ctx && ep < act_epoch) begin
      expect_beat(ST_ACT_REJECT, 1'b0, '0, '0, 1'b1);
    end else begin
      chg        = !has_ctx || ep != act_epoch || usr != act_user;
      has_ctx    = 1'b1;
      act_epoch  = ep;
      act_user   = usr;
      held_bytes = '0;
      expect_beat(ST_ACT_ACCEPT, chg, '0, '0, held_events.size() == 0);
      while (held_events.size() > 0) begin
        h = held_events.pop_front();
        expect_beat(ST_RELEASED, 1'b0, h.tag, h.size, held_events.size() == 0);
      end
    end
  endtask

  task automatic check_field(input string what, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) report_mismatch($sformatf("%s is %0h, expected %0h", what, got, want));
  endtask

  task automatic check_result();
    beat_t want;
    if (due_beats.size() == 0) begin
      report_mismatch("result beat with nothing expected");
    end else begin
      want = due_beats.pop_front();
      check_field("status", 32'(out_status), 32'(want.status));
      check_field("changed", 32'(out_changed), 32'(want.changed));
      check_field("tag", out_tag, want.tag);
      check_field("size", 32'(out_size), 32'(want.size));
      check_field("last", 32'(out_last), 32'(want.last));
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_fence();
      lim_events = MAX_EVENTS_RST;
      lim_bytes  = MAX_BYTES_RST;
      due_beats.delete();
    end else begin
      if (out_valid && out_ready) check_result();
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_MAX_EVENTS) lim_events = cfg_data[MAXEV_W-1:0];
        else if (cfg_index == REG_MAX_BYTES) lim_bytes = cfg_data;
      end
      if (in_valid && in_ready) begin
        case (cmd_t'(in_cmd))
          CMD_ADMIT: begin
            admit_event(in_epoch, in_user_id, in_event_tag, in_event_size);
          end
          CMD_ACTIVATE: begin
            activate_ctx(in_epoch, in_user_id);
          end
          CMD_RESET: begin
            clear_fence();
            expect_beat(ST_RESET_DONE, 1'b0, '0, '0, 1'b1);
          end
          default: begin
          end
        endcase
      end
    end
    pending <= due_beats.size();
  end

endmodule

@@ tb/epoch_fence_bounded_queue_top_tb.sv @@
`timescale 1ns / 100ps

module epoch_fence_bounded_queue_top_tb;
  import efbq_pkg::*;

  localparam int DRAIN_CYCLES = 2 * QUEUE_DEPTH_DEF + 8;
  localparam int SEGMENTS     = 6;
  localparam int SEG_ITEMS    = 58;

  logic                  clk           = 1'b0;
  logic                  rst_n         = 1'b0;
  logic                  in_valid      = 1'b0;
  logic                  in_ready;
  logic [CMD_W-1:0]      in_cmd        = '0;
  logic [EPOCH_W-1:0]    in_epoch      = '0;
  logic [USER_W-1:0]     in_user_id    = '0;
  logic [TAG_W-1:0]      in_event_tag  = '0;
  logic [SIZE_W-1:0]     in_event_size = '0;
  logic                  cfg_valid     = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index     = '0;
  logic [CFG_DATA_W-1:0] cfg_data      = '0;
  logic                  out_valid;
  logic                  out_ready     = 1'b0;
  logic [STATUS_W-1:0]   out_status;
  logic                  out_changed;
  logic [TAG_W-1:0]      out_tag;
  logic [SIZE_W-1:0]     out_size;
  logic                  out_last;

  int                 fail_count;
  int                 pending;
  int                 in_idle_pct  = 6;
  int                 out_idle_pct = 52;
  int                 sent;
  logic [EPOCH_W-1:0] ep_base    = '0;
  logic [USER_W-1:0]  cur_user   = '0;
  logic [SIZE_W-1:0]  cur_budget = MAX_BYTES_RST;
  logic [MAXEV_W-1:0] seg_events[SEGMENTS] = '{5'd16, 5'd4, 5'd31, 5'd0, 5'd9, 5'd16};
  logic [SIZE_W-1:0]  seg_bytes[SEGMENTS]  =
    '{20'd65536, 20'd5000, 20'd1048575, 20'd0, 20'd1000, 20'd300000};

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) out_ready <= ($urandom_range(99) >= out_idle_pct);

  epoch_fence_bounded_queue_top uut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_cmd        (in_cmd),
    .in_epoch      (in_epoch),
    .in_user_id    (in_user_id),
    .in_event_tag  (in_event_tag),
    .in_event_size (in_event_size),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_status    (out_status),
    .out_changed   (out_changed),
    .out_tag       (out_tag),
    .out_size      (out_size),
    .out_last      (out_last)
  );

  efbq_fence_checker fence_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_cmd        (in_cmd),
    .in_epoch      (in_epoch),
    .in_user_id    (in_user_id),
    .in_event_tag  (in_event_tag),
    .in_event_size (in_event_size),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_status    (out_status),
    .out_changed   (out_changed),
    .out_tag       (out_tag),
    .out_size      (out_size),
    .out_last      (out_last),
    .fail_count    (fail_count),
    .pending       (pending)
  );

  task automatic send_cmd(input cmd_t c, input logic [EPOCH_W-1:0] ep,
                          input logic [USER_W-1:0] usr, input logic [TAG_W-1:0] t,
                          input logic [SIZE_W-1:0] s);
    int gap;
    gap = 0;
    while (gap < 12 && $urandom_range(99) < in_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_cmd        <= c;
    in_epoch      <= ep;
    in_user_id    <= usr;
    in_event_tag  <= t;
    in_event_size <= s;
    do @(posedge clk); while (!in_ready);
    if (c != CMD_IGNORED) sent++;
  endtask

  // hold off until every expected beat is back, then let the back end settle
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_limits(input logic [MAXEV_W-1:0] ev, input logic [SIZE_W-1:0] cap);
    logic [CFG_DATA_W-1:0] junk;
    junk = CFG_DATA_W'($urandom);
    cfg_valid <= 1'b1;
    cfg_index <= REG_MAX_EVENTS;
    cfg_data  <= {junk[CFG_DATA_W-1:MAXEV_W], ev};
    do @(posedge clk); while (!cfg_ready);
    cfg_index <= REG_MAX_BYTES;
    cfg_data  <= cap;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cur_budget = cap;
  endtask

  function automatic logic [SIZE_W-1:0] pick_size(input logic [SIZE_W-1:0] bm);
    int r;
    r = $urandom_range(99);
    if (r < 40) return SIZE_W'($urandom_range(255));
    if (r < 60) return SIZE_W'($urandom_range(bm / 3));
    if (r < 72) return SIZE_W'($urandom_range(bm));
    if (r < 80) return bm;
    if (r < 88) return (bm == '1) ? bm : bm + 1'b1;
    return SIZE_W'($urandom);
  endfunction

  function automatic logic [USER_W-1:0] pick_user();
    int r;
    r = $urandom_range(99);
    if (r < 60) return cur_user;
    if (r < 85) return $urandom_range(3);
    return $urandom;
  endfunction

  function automatic logic [EPOCH_W-1:0] older_epoch();
    return (ep_base == 0) ? '0 : $urandom_range(ep_base - 1);
  endfunction

  task automatic run_burst();
    int                 n;
    int                 r;
    logic [EPOCH_W-1:0] ep;
    logic [USER_W-1:0]  usr;
    if (ep_base > 32'hFFFF_FF00 || $urandom_range(99) < 4) begin
      send_cmd(CMD_RESET, $urandom, $urandom, $urandom, SIZE_W'($urandom));
      ep_base = '0;
    end
    n = $urandom_range(20);
    repeat (n) begin
      r = $urandom_range(99);
      if (r < 70) begin
        send_cmd(CMD_ADMIT, ep_base + $urandom_range(3, 1), pick_user(), $urandom,
                 pick_size(cur_budget));
      end else if (r < 78) begin
        send_cmd(CMD_ADMIT, ep_base, pick_user(), $urandom, pick_size(cur_budget));
      end else if (r < 84) begin
        send_cmd(CMD_ADMIT, older_epoch(), pick_user(), $urandom, pick_size(cur_budget));
      end else if (r < 88) begin
        send_cmd(CMD_ADMIT, $urandom, $urandom, $urandom, SIZE_W'($urandom));
      end else if (r < 93) begin
        send_cmd(CMD_IGNORED, $urandom, $urandom, $urandom, SIZE_W'($urandom));
      end else if (r < 98) begin
        send_cmd(CMD_ACTIVATE, older_epoch(), pick_user(), $urandom, SIZE_W'($urandom));
      end else begin
        send_cmd(CMD_RESET, $urandom, $urandom, $urandom, SIZE_W'($urandom));
        ep_base = '0;
      end
    end
    ep  = ($urandom_range(99) < 4) ? $urandom : ep_base + $urandom_range(4);
    usr = pick_user();
    send_cmd(CMD_ACTIVATE, ep, usr, $urandom, SIZE_W'($urandom));
    if (ep >= ep_base) begin
      ep_base  = ep;
      cur_user = usr;
    end
  endtask

  initial begin
    int seg;
    int paused;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_cmd(CMD_ADMIT, 32'd5, 32'd7, 32'hA000_0001, 20'd100);
    send_cmd(CMD_ADMIT, 32'd0, 32'd0, 32'h0000_0000, 20'd0);
    send_cmd(CMD_ADMIT, 32'd9, 32'd7, 32'hA000_0003, 20'hFFFFF);
    send_cmd(CMD_IGNORED, 32'd6, 32'd7, 32'hA000_0004, 20'd5);
    send_cmd(CMD_ACTIVATE, 32'd5, 32'd7, 32'h0, 20'd0);
    send_cmd(CMD_ADMIT, 32'd5, 32'd7, 32'hA000_0006, 20'd10);
    send_cmd(CMD_ADMIT, 32'd5, 32'd8, 32'hA000_0007, 20'd10);
    send_cmd(CMD_ADMIT, 32'd4, 32'd7, 32'hA000_0008, 20'd10);
    send_cmd(CMD_ACTIVATE, 32'd5, 32'd7, 32'h0, 20'd0);
    send_cmd(CMD_ACTIVATE, 32'd3, 32'd7, 32'h0, 20'd0);
    send_cmd(CMD_ADMIT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 20'd65536);
    send_cmd(CMD_ADMIT, 32'd6, 32'd7, 32'hA000_000C, 20'd1);
    send_cmd(CMD_ACTIVATE, 32'hFFFF_FFFF, 32'd0, 32'h0, 20'd0);
    send_cmd(CMD_RESET, 32'd0, 32'd0, 32'h0, 20'd0);
    send_cmd(CMD_ACTIVATE, 32'd0, 32'd0, 32'h0, 20'd0);
    send_cmd(CMD_RESET, 32'd0, 32'd0, 32'h0, 20'd0);
    drain();
    set_limits(5'd0, 20'd0);
    send_cmd(CMD_ADMIT, 32'd1, 32'd1, 32'hA000_0011, 20'd0);
    send_cmd(CMD_ADMIT, 32'd2, 32'd1, 32'hA000_0012, 20'd0);
    send_cmd(CMD_ADMIT, 32'd3, 32'd1, 32'hA000_0013, 20'd1);
    send_cmd(CMD_ACTIVATE, 32'd3, 32'd1, 32'h0, 20'd0);
    drain();
    set_limits(5'd31, 20'd1000);
    send_cmd(CMD_ADMIT, 32'd4, 32'd1, 32'hA000_0015, 20'd300);
    send_cmd(CMD_ADMIT, 32'd5, 32'd1, 32'hA000_0016, 20'd300);
    send_cmd(CMD_ADMIT, 32'd6, 32'd1, 32'hA000_0017, 20'd300);
    drain();
    set_limits(5'd31, 20'd500);
    send_cmd(CMD_ADMIT, 32'd7, 32'd1, 32'hA000_0018, 20'd10);
    send_cmd(CMD_ACTIVATE, 32'd7, 32'd1, 32'h0, 20'd0);
    ep_base  = 32'd7;
    cur_user = 32'd1;

    for (seg = 0; seg < SEGMENTS; seg++) begin
      drain();
      in_idle_pct  = (seg < 2) ? 6 : ((seg < 4) ? 52 : 0);
      out_idle_pct <= (seg < 2) ? 52 : ((seg < 4) ? 6 : 0);
      set_limits(seg_events[seg], seg_bytes[seg]);
      sent   = 0;
      paused = 0;
      while (sent < SEG_ITEMS) begin
        run_burst();
        if (paused == 0 && sent >= SEG_ITEMS / 2) begin
          drain();
          paused = 1;
        end
      end
    end

    drain();
    if (fail_count == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    #8_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

@@ sim.f @@
src/efbq_pkg.sv
src/efbq_ram.sv
src/efbq_front.sv
src/efbq_back.sv
src/epoch_fence_bounded_queue_top.sv
tb/efbq_fence_checker.sv
tb/epoch_fence_bounded_queue_top_tb.sv
